FILE: rtl/indexed_ordered_membership_list_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the indexed ordered membership list
// Shorthand for clocked assertions with a synchronous reset that disables them.
// ----------------------------------------------------------------------------
`ifndef INDEXED_ORDERED_MEMBERSHIP_LIST_MACROS_SVH
`define INDEXED_ORDERED_MEMBERSHIP_LIST_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define IOL_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define IOL_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/iol_pkg.sv
// ----------------------------------------------------------------------------
// iol_pkg
// Types, constants and helpers shared by the ordered membership list.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package iol_pkg;

   localparam int SLOT_COUNT = 1024;
   localparam int IDX_W      = $clog2(SLOT_COUNT);
   localparam int LINK_W     = IDX_W + 1;
   localparam int SLOT_W     = 10;
   localparam int POS_W      = 64;
   localparam int CNT_W      = 64;
   localparam int LINK_WORD_W = 2 * LINK_W;
   localparam int DATA_WORD_W = 2 * POS_W + 1;

   typedef logic [LINK_W-1:0] link_type;
   typedef logic [IDX_W-1:0]  idx_type;

   localparam link_type NULL_LINK = link_type'(SLOT_COUNT);

   localparam logic [LINK_WORD_W-1:0] MASK_ALL  = {LINK_WORD_W{1'b1}};
   localparam logic [LINK_WORD_W-1:0] MASK_NEXT = {{LINK_W{1'b1}}, {LINK_W{1'b0}}};
   localparam logic [LINK_WORD_W-1:0] MASK_PREV = {{LINK_W{1'b0}}, {LINK_W{1'b1}}};

   typedef enum logic [1:0] {
      FUNC_PUSH   = 2'd0,
      FUNC_REMOVE = 2'd1,
      FUNC_POP    = 2'd2,
      FUNC_NOP    = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      STAT_DONE    = 2'd0,
      STAT_ALREADY = 2'd1,
      STAT_ABSENT  = 2'd2,
      STAT_EMPTY   = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_LOOK,
      S_FIX_NEXT,
      S_FIX_PREV,
      S_DONE
   } state_type;

   typedef struct packed {
      link_type next_link;
      link_type prev_link;
   } link_word_type;

   typedef struct packed {
      logic [POS_W-1:0] redo_pos;
      logic [POS_W-1:0] point_pos;
      logic             candidate;
   } data_word_type;

   typedef struct packed {
      logic clear_last;
      logic req_valid;
      logic plan_next;
      logic plan_prev;
      logic out_free;
   } seq_flags_type;

   typedef struct packed {
      logic clearing;
      logic ready;
      logic look;
      logic fix_next;
      logic fix_prev;
      logic load_out;
   } seq_ctrl_type;

   typedef struct packed {
      status_type        status;
      logic [SLOT_W-1:0] out_slot;
      logic [POS_W-1:0]  out_redo_pos;
      logic [POS_W-1:0]  out_point_pos;
      logic              out_candidate;
      logic              head_valid;
      logic [SLOT_W-1:0] head_slot;
      logic [CNT_W-1:0]  push_total;
      logic [CNT_W-1:0]  remove_total;
      logic [CNT_W-1:0]  pop_total;
   } result_type;

   function automatic logic link_valid(input link_type l);
      return l < NULL_LINK;
   endfunction

   function automatic logic slot_in_range(input logic [SLOT_W-1:0] s);
      return 32'(s) < 32'(SLOT_COUNT);
   endfunction

endpackage

`default_nettype wire

FILE: rtl/iol_channels.sv
// ----------------------------------------------------------------------------
// iol channels
// Valid/ready channels for request words and response words.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface iol_req_if;
   logic                           valid;
   logic                           ready;
   logic [1:0]                     func;
   logic [iol_pkg::SLOT_W-1:0]     slot;
   logic                           want_candidate;
   logic                           page_pos_invalid;
   logic [iol_pkg::POS_W-1:0]      redo_pos;
   logic [iol_pkg::POS_W-1:0]      point_pos;

   modport source (
      output valid, func, slot, want_candidate, page_pos_invalid, redo_pos, point_pos,
      input  ready
   );
   modport sink (
      input  valid, func, slot, want_candidate, page_pos_invalid, redo_pos, point_pos,
      output ready
   );
endinterface

interface iol_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [1:0]                     status;
   logic [iol_pkg::SLOT_W-1:0]     out_slot;
   logic [iol_pkg::POS_W-1:0]      out_redo_pos;
   logic [iol_pkg::POS_W-1:0]      out_point_pos;
   logic                           out_candidate;
   logic                           head_valid;
   logic [iol_pkg::SLOT_W-1:0]     head_slot;
   logic [iol_pkg::CNT_W-1:0]      push_total;
   logic [iol_pkg::CNT_W-1:0]      remove_total;
   logic [iol_pkg::CNT_W-1:0]      pop_total;

   modport source (
      output valid, status, out_slot, out_redo_pos, out_point_pos, out_candidate,
             head_valid, head_slot, push_total, remove_total, pop_total,
      input  ready
   );
   modport sink (
      input  valid, status, out_slot, out_redo_pos, out_point_pos, out_candidate,
             head_valid, head_slot, push_total, remove_total, pop_total,
      output ready
   );
endinterface

`default_nettype wire

FILE: rtl/iol_ram.sv
// ----------------------------------------------------------------------------
// iol_ram
// Single-port-write, single-port-read RAM with bit mask and registered read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module iol_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [WIDTH-1:0]         wr_mask,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         for (int b = 0; b < WIDTH; b++) begin
            if (wr_mask[b]) begin
               mem_ff[wr_addr][b] <= wr_data[b];
            end
         end
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: rtl/iol_seq.sv
// ----------------------------------------------------------------------------
// iol_seq
// Sequencer for the clearing pass and the read, link-fix and reply steps.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module iol_seq (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire iol_pkg::seq_flags_type flags,
   output iol_pkg::seq_ctrl_type       ctrl
);

   iol_pkg::state_type state_ff;
   iol_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= iol_pkg::S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         iol_pkg::S_CLEAR: begin
            if (flags.clear_last) state_in = iol_pkg::S_IDLE;
         end
         iol_pkg::S_IDLE: begin
            if (flags.req_valid) state_in = iol_pkg::S_LOOK;
         end
         iol_pkg::S_LOOK: begin
            if (flags.plan_next) begin
               state_in = iol_pkg::S_FIX_NEXT;
            end else if (flags.plan_prev) begin
               state_in = iol_pkg::S_FIX_PREV;
            end else begin
               state_in = iol_pkg::S_DONE;
            end
         end
         iol_pkg::S_FIX_NEXT: begin
            state_in = flags.plan_prev ? iol_pkg::S_FIX_PREV : iol_pkg::S_DONE;
         end
         iol_pkg::S_FIX_PREV: begin
            state_in = iol_pkg::S_DONE;
         end
         iol_pkg::S_DONE: begin
            if (flags.out_free) state_in = iol_pkg::S_IDLE;
         end
         default: begin
            state_in = iol_pkg::S_CLEAR;
         end
      endcase
   end

   always_comb begin
      ctrl = '0;
      case (state_ff)
         iol_pkg::S_CLEAR:    ctrl.clearing = 1'b1;
         iol_pkg::S_IDLE:     ctrl.ready    = 1'b1;
         iol_pkg::S_LOOK:     ctrl.look     = 1'b1;
         iol_pkg::S_FIX_NEXT: ctrl.fix_next = 1'b1;
         iol_pkg::S_FIX_PREV: ctrl.fix_prev = 1'b1;
         iol_pkg::S_DONE:     ctrl.load_out = flags.out_free;
         default:             ctrl = '0;
      endcase
   end

endmodule

`default_nettype wire

FILE: rtl/indexed_ordered_membership_list.sv
// ----------------------------------------------------------------------------
// indexed_ordered_membership_list
// A fixed set of slots linked in insertion order, with push, remove and pop.
//
// Usage: request words arrive on req_ch (push a slot at the tail, remove a
// given slot, or pop the head) and exactly one response word per request
// leaves on rsp_ch, carrying the status, the stored fields of a removed slot,
// the head after the step and the three running counters.
// The links live in one RAM and the stored positions in a second; each
// request reads both once, then writes the links one entry per cycle.
// The RAM read is issued at the accepting edge, and rsp_ch.valid rises after
// a write step that also computes the reply, up to two neighbor fixes, and
// the load of the response register, which waits until that register is
// free. The next request is taken only after that load, so a request is not
// accepted while the previous one is still in progress.
// After reset the block writes null links into all SLOT_COUNT entries, one
// entry a cycle, and holds req_ch.ready low meanwhile.
// The response register lets a new request be taken while a response waits;
// a second response then waits in the sequencer until rsp_ch.ready frees it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "indexed_ordered_membership_list_macros.svh"

module indexed_ordered_membership_list (
   input  wire logic clock,
   input  wire logic reset,
   iol_req_if.sink   req_ch,
   iol_rsp_if.source rsp_ch
);

   iol_pkg::seq_flags_type flags;
   iol_pkg::seq_ctrl_type  ctrl;

   logic                          accept;
   iol_pkg::func_type             req_func;
   iol_pkg::idx_type              tgt_in;
   logic                          tgt_ok_in;

   iol_pkg::idx_type              clr_cnt_ff;
   iol_pkg::link_type             head_ff, head_in;
   iol_pkg::link_type             tail_ff, tail_in;
   logic [iol_pkg::CNT_W-1:0]     push_ff, push_in;
   logic [iol_pkg::CNT_W-1:0]     remove_ff, remove_in;
   logic [iol_pkg::CNT_W-1:0]     pop_ff, pop_in;

   iol_pkg::func_type             op_ff;
   logic [iol_pkg::SLOT_W-1:0]    slot_ff;
   iol_pkg::idx_type              tgt_ff;
   logic                          tgt_ok_ff;
   logic                          cand_ff;
   logic [iol_pkg::POS_W-1:0]     redo_ff;
   logic [iol_pkg::POS_W-1:0]     point_ff;

   logic                          plan_next_ff, plan_next_in;
   logic                          plan_prev_ff, plan_prev_in;
   iol_pkg::idx_type              fixn_addr_ff, fixn_addr_in;
   iol_pkg::link_type             fixn_val_ff, fixn_val_in;
   iol_pkg::idx_type              fixp_addr_ff, fixp_addr_in;
   iol_pkg::link_type             fixp_val_ff, fixp_val_in;

   iol_pkg::result_type           res_ff, res_in;
   iol_pkg::result_type           out_ff;
   logic                          rsp_valid_ff;

   logic                          look_link_wr;
   iol_pkg::link_word_type        look_link_wd;
   logic                          look_data_wr;

   logic [iol_pkg::LINK_WORD_W-1:0] link_rd_data;
   logic [iol_pkg::DATA_WORD_W-1:0] data_rd_data;
   iol_pkg::link_word_type        lk;
   iol_pkg::data_word_type        dt;
   iol_pkg::link_type             tgt_link;
   logic                          is_member;

   logic                            lw_en;
   iol_pkg::idx_type                lw_addr;
   logic [iol_pkg::LINK_WORD_W-1:0] lw_data;
   logic [iol_pkg::LINK_WORD_W-1:0] lw_mask;
   iol_pkg::data_word_type          dw_data;

   assign accept   = ctrl.ready & req_ch.valid;
   assign req_func = iol_pkg::func_type'(req_ch.func);
   assign req_ch.ready = ctrl.ready;

   always_comb begin
      if (req_func == iol_pkg::FUNC_POP) begin
         tgt_in    = iol_pkg::IDX_W'(head_ff);
         tgt_ok_in = iol_pkg::link_valid(head_ff);
      end else begin
         tgt_in    = iol_pkg::IDX_W'(req_ch.slot);
         tgt_ok_in = iol_pkg::slot_in_range(req_ch.slot);
      end
   end

   assign flags.clear_last = (clr_cnt_ff == iol_pkg::IDX_W'(iol_pkg::SLOT_COUNT - 1));
   assign flags.req_valid  = req_ch.valid;
   assign flags.plan_next  = ctrl.look ? plan_next_in : plan_next_ff;
   assign flags.plan_prev  = ctrl.look ? plan_prev_in : plan_prev_ff;
   assign flags.out_free   = ~rsp_valid_ff | rsp_ch.ready;

   iol_seq u_seq (
      .clock (clock),
      .reset (reset),
      .flags (flags),
      .ctrl  (ctrl)
   );

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff     <= req_func;
         slot_ff   <= req_ch.slot;
         tgt_ff    <= tgt_in;
         tgt_ok_ff <= tgt_ok_in;
         cand_ff   <= req_ch.want_candidate | req_ch.page_pos_invalid;
         redo_ff   <= req_ch.redo_pos;
         point_ff  <= req_ch.point_pos;
      end
      if (ctrl.look) begin
         plan_next_ff <= plan_next_in;
         plan_prev_ff <= plan_prev_in;
         fixn_addr_ff <= fixn_addr_in;
         fixn_val_ff  <= fixn_val_in;
         fixp_addr_ff <= fixp_addr_in;
         fixp_val_ff  <= fixp_val_in;
         res_ff       <= res_in;
      end
      if (ctrl.load_out) begin
         out_ff <= res_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff   <= '0;
         head_ff      <= iol_pkg::NULL_LINK;
         tail_ff      <= iol_pkg::NULL_LINK;
         push_ff      <= '0;
         remove_ff    <= '0;
         pop_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (ctrl.clearing) begin
            clr_cnt_ff <= clr_cnt_ff + 1'b1;
         end
         head_ff   <= head_in;
         tail_ff   <= tail_in;
         push_ff   <= push_in;
         remove_ff <= remove_in;
         pop_ff    <= pop_in;
         if (ctrl.load_out) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign lk        = iol_pkg::link_word_type'(link_rd_data);
   assign dt        = iol_pkg::data_word_type'(data_rd_data);
   assign tgt_link  = iol_pkg::LINK_W'(tgt_ff);
   assign is_member = tgt_ok_ff &
                      (iol_pkg::link_valid(lk.prev_link) | (head_ff == tgt_link));

   always_comb begin
      head_in      = head_ff;
      tail_in      = tail_ff;
      push_in      = push_ff;
      remove_in    = remove_ff;
      pop_in       = pop_ff;
      plan_next_in = 1'b0;
      plan_prev_in = 1'b0;
      fixn_addr_in = iol_pkg::IDX_W'(lk.prev_link);
      fixn_val_in  = lk.next_link;
      fixp_addr_in = iol_pkg::IDX_W'(lk.next_link);
      fixp_val_in  = lk.prev_link;
      look_link_wr = 1'b0;
      look_link_wd = '{next_link: iol_pkg::NULL_LINK, prev_link: iol_pkg::NULL_LINK};
      look_data_wr = 1'b0;
      res_in       = '0;
      res_in.status = iol_pkg::STAT_DONE;

      if (ctrl.look) begin
         case (op_ff)
            iol_pkg::FUNC_PUSH: begin
               res_in.out_slot = slot_ff;
               if (!tgt_ok_ff) begin
                  res_in.status = iol_pkg::STAT_ABSENT;
               end else if (is_member) begin
                  res_in.status = iol_pkg::STAT_ALREADY;
               end else begin
                  look_link_wr = 1'b1;
                  look_link_wd.prev_link = tail_ff;
                  look_data_wr = 1'b1;
                  if (iol_pkg::link_valid(tail_ff)) begin
                     plan_next_in = 1'b1;
                     fixn_addr_in = iol_pkg::IDX_W'(tail_ff);
                     fixn_val_in  = tgt_link;
                  end else begin
                     head_in = tgt_link;
                  end
                  tail_in = tgt_link;
                  push_in = push_ff + 1'b1;
               end
            end
            iol_pkg::FUNC_REMOVE, iol_pkg::FUNC_POP: begin
               res_in.out_slot = (op_ff == iol_pkg::FUNC_REMOVE) ? slot_ff : '0;
               if (!is_member) begin
                  res_in.status = (op_ff == iol_pkg::FUNC_REMOVE) ?
                                  iol_pkg::STAT_ABSENT : iol_pkg::STAT_EMPTY;
               end else begin
                  res_in.out_slot      = iol_pkg::SLOT_W'(tgt_ff);
                  res_in.out_redo_pos  = dt.redo_pos;
                  res_in.out_point_pos = dt.point_pos;
                  res_in.out_candidate = dt.candidate;
                  look_link_wr = 1'b1;
                  if (head_ff == tgt_link) begin
                     head_in = lk.next_link;
                  end else if (iol_pkg::link_valid(lk.prev_link)) begin
                     plan_next_in = 1'b1;
                  end
                  if (tail_ff == tgt_link) begin
                     tail_in = lk.prev_link;
                  end else if (iol_pkg::link_valid(lk.next_link)) begin
                     plan_prev_in = 1'b1;
                  end
                  remove_in = remove_ff + 1'b1;
                  if (op_ff == iol_pkg::FUNC_POP) begin
                     pop_in = pop_ff + 1'b1;
                  end
               end
            end
            default: begin
               res_in.status = iol_pkg::STAT_DONE;
            end
         endcase
      end

      res_in.head_valid   = iol_pkg::link_valid(head_in);
      res_in.head_slot    = res_in.head_valid ? iol_pkg::SLOT_W'(head_in) : '0;
      res_in.push_total   = push_in;
      res_in.remove_total = remove_in;
      res_in.pop_total    = pop_in;
   end

   always_comb begin
      lw_en   = 1'b0;
      lw_addr = clr_cnt_ff;
      lw_data = {iol_pkg::NULL_LINK, iol_pkg::NULL_LINK};
      lw_mask = iol_pkg::MASK_ALL;
      if (ctrl.clearing) begin
         lw_en = 1'b1;
      end else if (ctrl.look) begin
         lw_en   = look_link_wr;
         lw_addr = tgt_ff;
         lw_data = look_link_wd;
      end else if (ctrl.fix_next) begin
         lw_en   = 1'b1;
         lw_addr = fixn_addr_ff;
         lw_data = {fixn_val_ff, iol_pkg::NULL_LINK};
         lw_mask = iol_pkg::MASK_NEXT;
      end else if (ctrl.fix_prev) begin
         lw_en   = 1'b1;
         lw_addr = fixp_addr_ff;
         lw_data = {iol_pkg::NULL_LINK, fixp_val_ff};
         lw_mask = iol_pkg::MASK_PREV;
      end
   end

   assign dw_data = '{redo_pos: redo_ff, point_pos: point_ff, candidate: cand_ff};

   iol_ram #(
      .WIDTH (iol_pkg::LINK_WORD_W),
      .DEPTH (iol_pkg::SLOT_COUNT)
   ) u_link_ram (
      .clock   (clock),
      .wr_en   (lw_en),
      .wr_addr (lw_addr),
      .wr_data (lw_data),
      .wr_mask (lw_mask),
      .rd_en   (accept),
      .rd_addr (tgt_in),
      .rd_data (link_rd_data)
   );

   iol_ram #(
      .WIDTH (iol_pkg::DATA_WORD_W),
      .DEPTH (iol_pkg::SLOT_COUNT)
   ) u_data_ram (
      .clock   (clock),
      .wr_en   (look_data_wr),
      .wr_addr (tgt_ff),
      .wr_data (dw_data),
      .wr_mask ({iol_pkg::DATA_WORD_W{1'b1}}),
      .rd_en   (accept),
      .rd_addr (tgt_in),
      .rd_data (data_rd_data)
   );

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.status        = out_ff.status;
   assign rsp_ch.out_slot      = out_ff.out_slot;
   assign rsp_ch.out_redo_pos  = out_ff.out_redo_pos;
   assign rsp_ch.out_point_pos = out_ff.out_point_pos;
   assign rsp_ch.out_candidate = out_ff.out_candidate;
   assign rsp_ch.head_valid    = out_ff.head_valid;
   assign rsp_ch.head_slot     = out_ff.head_slot;
   assign rsp_ch.push_total    = out_ff.push_total;
   assign rsp_ch.remove_total  = out_ff.remove_total;
   assign rsp_ch.pop_total     = out_ff.pop_total;

   `IOL_ASSERT_SAME(a_no_accept_while_clearing, clock, reset,
                    ctrl.clearing, !req_ch.ready,
                    "request taken during clearing pass")
   `IOL_ASSERT_SAME(a_load_only_when_free, clock, reset,
                    ctrl.load_out, !rsp_valid_ff || rsp_ch.ready,
                    "response register overwritten")
   `IOL_ASSERT_SAME(a_head_tail_agree, clock, reset, 1'b1,
                    (head_ff == iol_pkg::NULL_LINK) == (tail_ff == iol_pkg::NULL_LINK),
                    "head and tail disagree on empty list")
   `IOL_ASSERT_NEXT(a_accept_then_look, clock, reset,
                    accept, ctrl.look,
                    "accepted request not looked up")

endmodule

`default_nettype wire
